@@ hdl/wrr_pkg.sv @@
// shared types and constants for the weighted round-robin port scheduler
// no dependencies; imported by every module of the block
package wrr_pkg;

    localparam int NUM_PORTS_DEF   = 8;
    localparam int WEIGHT_BITS_DEF = 8;

    // fixed field widths of the stream items
    localparam int PENDING_W    = 8;
    localparam int GRANT_PORT_W = 3;
    localparam int LANE_W       = 8;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 8;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 64;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PORT_ENABLE  = 1'b0,
        CFG_PORT_WEIGHTS = 1'b1
    } t_cfg_index;

    // one service slot as it arrives on the input stream
    typedef struct packed {
        logic                 start_round;
        logic                 previous_failed;
        logic [PENDING_W-1:0] pending_mask;
    } t_slot;

    // result of one slot
    typedef struct packed {
        logic [GRANT_PORT_W-1:0] grant_port;
        logic                    grant_valid;
    } t_grant;

endpackage

@@ hdl/wrr_cfg.sv @@
// configuration registers: port enable mask and per-port credit weights
// depends on wrr_pkg
module wrr_cfg #(
    parameter int NUM_PORTS   = wrr_pkg::NUM_PORTS_DEF,
    parameter int WEIGHT_BITS = wrr_pkg::WEIGHT_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [wrr_pkg::CFG_INDEX_W-1:0]        i_cfg_index,
    input  logic [wrr_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    output logic [NUM_PORTS-1:0]                   o_enable,
    output logic [NUM_PORTS-1:0][WEIGHT_BITS-1:0]  o_weights
);
    import wrr_pkg::*;

    logic [NUM_PORTS-1:0]                  r_enable;
    logic [NUM_PORTS-1:0][WEIGHT_BITS-1:0] r_weights;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= '0;
            r_weights <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_PORT_ENABLE: begin
                    r_enable <= i_cfg_data[NUM_PORTS-1:0];
                end
                CFG_PORT_WEIGHTS: begin
                    // only the low bits of each byte lane are kept
                    for (int n = 0; n < NUM_PORTS; n++) begin
                        r_weights[n] <= i_cfg_data[n*LANE_W +: WEIGHT_BITS];
                    end
                end
                default: begin
                    r_enable <= r_enable;
                end
            endcase
        end
    end

    assign o_enable  = r_enable;
    assign o_weights = r_weights;

endmodule

@@ hdl/wrr_core.sv @@
// turn and credit state with the rotating priority search for the next port
// depends on wrr_pkg
module wrr_core #(
    parameter int NUM_PORTS   = wrr_pkg::NUM_PORTS_DEF,
    parameter int WEIGHT_BITS = wrr_pkg::WEIGHT_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_fire,
    input  wrr_pkg::t_slot                         i_slot,
    input  logic [NUM_PORTS-1:0]                   i_enable,
    input  logic [NUM_PORTS-1:0][WEIGHT_BITS-1:0]  i_weights,
    output wrr_pkg::t_grant                        o_grant
);
    import wrr_pkg::*;

    localparam int PORT_W = $clog2(NUM_PORTS);

    logic [PORT_W-1:0]      r_turn,   n_turn;
    logic [WEIGHT_BITS-1:0] r_credit, n_credit;
    logic                   r_active, n_active;

    logic [NUM_PORTS-1:0]   cand;
    logic                   restart;
    logic                   hold;
    logic [PORT_W:0]        turn_inc;
    logic [PORT_W-1:0]      start_idx;
    logic [2*NUM_PORTS-1:0] cand_dbl;
    logic [NUM_PORTS-1:0]   cand_rot;
    logic                   found;
    logic [PORT_W-1:0]      offset;
    logic [PORT_W:0]        pos_sum;
    logic [PORT_W-1:0]      next_port;
    logic [WEIGHT_BITS-1:0] next_weight;

    assign cand    = i_slot.pending_mask[NUM_PORTS-1:0] & i_enable;
    assign restart = i_slot.start_round || !r_active;
    assign hold    = !restart && !i_slot.previous_failed && (r_credit != '0) && cand[r_turn];

    // search opens at port 0 on a restart, else just after the current turn
    assign turn_inc  = {1'b0, r_turn} + (PORT_W+1)'(1);
    assign start_idx = restart ? '0 :
                       (turn_inc == (PORT_W+1)'(NUM_PORTS)) ? '0 : turn_inc[PORT_W-1:0];

    assign cand_dbl = {cand, cand} >> start_idx;
    assign cand_rot = cand_dbl[NUM_PORTS-1:0];

    always_comb begin
        found  = 1'b0;
        offset = '0;
        for (int i = NUM_PORTS - 1; i >= 0; i--) begin
            if (cand_rot[i]) begin
                found  = 1'b1;
                offset = PORT_W'(i);
            end
        end
    end

    assign pos_sum   = {1'b0, start_idx} + {1'b0, offset};
    assign next_port = (pos_sum >= (PORT_W+1)'(NUM_PORTS)) ?
                       PORT_W'(pos_sum - (PORT_W+1)'(NUM_PORTS)) : pos_sum[PORT_W-1:0];
    assign next_weight = i_weights[next_port];

    always_comb begin
        n_turn   = r_turn;
        n_credit = r_credit;
        n_active = r_active;
        o_grant  = '0;
        if (hold) begin
            n_credit            = r_credit - WEIGHT_BITS'(1);
            o_grant.grant_valid = 1'b1;
            o_grant.grant_port  = GRANT_PORT_W'(r_turn);
        end else if (found) begin
            n_turn   = next_port;
            n_active = 1'b1;
            // a zero weight counts as one, so nothing is left after this grant
            n_credit = (next_weight == '0) ? '0 : next_weight - WEIGHT_BITS'(1);
            o_grant.grant_valid = 1'b1;
            o_grant.grant_port  = GRANT_PORT_W'(next_port);
        end else begin
            n_credit = '0;
            if (i_slot.start_round) begin
                n_active = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turn   <= '0;
            r_credit <= '0;
            r_active <= 1'b0;
        end else if (i_fire) begin
            r_turn   <= n_turn;
            r_credit <= n_credit;
            r_active <= n_active;
        end
    end

endmodule

@@ hdl/weighted_round_robin_port_scheduler_unit.sv @@
// weighted round-robin port scheduler: one grant decision per item
// path from input accept to result valid: input register, then result register
// throughput: one item per cycle while the result stream is not stalled, set by the turn/credit update in wrr_core
// the input register keeps taking items while a result waits, as long as it can move on
// reset (synchronous, active low): no turn held, credit zero, all ports disabled, weights zero
module weighted_round_robin_port_scheduler_unit #(
    parameter int NUM_PORTS   = wrr_pkg::NUM_PORTS_DEF,
    parameter int WEIGHT_BITS = wrr_pkg::WEIGHT_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [wrr_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [wrr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [7:0] pending_mask, [8] previous_failed, [9] start_round, [15:10] zero
    input  logic [wrr_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [0] grant_valid, [3:1] grant_port, [7:4] zero
    output logic [wrr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import wrr_pkg::*;

    logic [NUM_PORTS-1:0]                  enable;
    logic [NUM_PORTS-1:0][WEIGHT_BITS-1:0] weights;

    logic   r_in_valid;
    t_slot  r_in_slot;
    logic   r_out_valid;
    t_grant r_out_grant;

    logic   advance;
    logic   in_fire;
    t_grant grant;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_slot <= t_slot'(s_axis_tdata[$bits(t_slot)-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_grant <= grant;
        end
    end

    wrr_cfg #(
        .NUM_PORTS   (NUM_PORTS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_enable    (enable),
        .o_weights   (weights)
    );

    wrr_core #(
        .NUM_PORTS   (NUM_PORTS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (advance),
        .i_slot    (r_in_slot),
        .i_enable  (enable),
        .i_weights (weights),
        .o_grant   (grant)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out_grant);

endmodule

@@ hdl/wrr_checker.sv @@
// port-level checks on the result stream of the scheduler
// depends on wrr_pkg; attached to the top level by the bind below
module wrr_checker #(
    parameter int NUM_PORTS = wrr_pkg::NUM_PORTS_DEF
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_m_tvalid,
    input logic                            i_m_tready,
    input logic [wrr_pkg::OUT_TDATA_W-1:0] i_m_tdata
);
    import wrr_pkg::*;

    // a stalled result holds its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> $stable(i_m_tdata))
        else $error("result changed while stalled");

    // no grant means port zero
    a_idle_port_zero: assert property (@(posedge i_clk)
        i_m_tvalid && !i_m_tdata[0] |-> i_m_tdata[3:1] == 3'd0)
        else $error("grant_port nonzero without a grant");

    // a granted port exists and padding stays clear
    a_port_range: assert property (@(posedge i_clk)
        i_m_tvalid |-> ({1'b0, i_m_tdata[3:1]} < (GRANT_PORT_W+1)'(NUM_PORTS)) &&
                       (i_m_tdata[7:4] == 4'd0))
        else $error("grant_port out of range or padding set");

    // nothing comes out in the cycle after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_m_tvalid)
        else $error("result valid right after reset");

endmodule

bind weighted_round_robin_port_scheduler_unit wrr_checker #(
    .NUM_PORTS (NUM_PORTS)
) u_wrr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);
